>>> rtl/core/fpst_pkg.sv
package fpst_pkg;

    localparam int NUM_POS    = 1024;
    localparam int SUM_BITS   = 64;
    localparam int ADDR_BITS  = $clog2(NUM_POS);
    localparam int POS_BITS   = $clog2(NUM_POS + 1);
    localparam int NXT_BITS   = POS_BITS + 1;
    localparam int SEARCH_TOP = 1 << (POS_BITS - 1);

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 64;
    localparam int FOUND_W = 11;

    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SRCH = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUM,
        OP_SRCH,
        OP_NONE
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [POS_BITS-1:0]   start;
        logic [SUM_BITS-1:0]   operand;
        logic                  err;
    } fpst_op_t;

endpackage

>>> rtl/core/fenwick_prefix_sum_tree_core.sv
// Binary indexed tree over 1024 positions holding 64-bit wrapping sums. After reset the
// block clears the tree store and takes no item until that is done. Each item then runs
// on a node store with one read and one write port, one node per cycle: point add
// touches 1 to 11 nodes, prefix sum 1 to 10 nodes and lower bound always takes 11 steps,
// plus a start step in the idle state and a response step that hands the result to the
// output register. A two-entry queue in front of the engine lets up to two items be taken
// while one is still running, and the output register lets the engine start the next item
// while a result waits. Index errors and the unused command skip the tree walk.
module fenwick_prefix_sum_tree_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fpst_pkg::CMD_W-1:0]    command,
    input  logic [fpst_pkg::IDX_W-1:0]    position_index,
    input  logic [fpst_pkg::VAL_W-1:0]    operand_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fpst_pkg::VAL_W-1:0]    prefix_total,
    output logic [fpst_pkg::FOUND_W-1:0]  found_position,
    output logic                          index_error
);
    import fpst_pkg::*;

    fpst_op_t head;
    logic     head_valid;
    logic     pop;
    logic     clear_done;

    fpst_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable         (clear_done),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .position_index (position_index),
        .operand_value  (operand_value),
        .pop            (pop),
        .head_valid     (head_valid),
        .head           (head)
    );

    fpst_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .clear_done     (clear_done),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .prefix_total   (prefix_total),
        .found_position (found_position),
        .index_error    (index_error)
    );

endmodule

>>> rtl/core/fpst_front.sv
module fpst_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enable,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fpst_pkg::CMD_W-1:0]  command,
    input  logic [fpst_pkg::IDX_W-1:0]  position_index,
    input  logic [fpst_pkg::VAL_W-1:0]  operand_value,
    input  logic                        pop,
    output logic                        head_valid,
    output fpst_pkg::fpst_op_t          head
);
    import fpst_pkg::*;

    fpst_op_t            q_reg [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                range_err;
    fpst_op_t            op;

    // classify the incoming item
    assign range_err = 32'(position_index) >= 32'(NUM_POS);

    always_comb
    begin
        op.start   = POS_BITS'(position_index) + POS_BITS'(1);
        op.operand = operand_value[SUM_BITS-1:0];
        op.err     = 1'b0;
        op.kind    = OP_NONE;
        case (command)
            CMD_ADD, CMD_SUM:
            begin
                if (range_err)
                begin
                    op.err = 1'b1;
                end
                else
                begin
                    op.kind = (command == CMD_ADD) ? OP_ADD : OP_SUM;
                end
            end
            CMD_SRCH:
            begin
                op.kind = OP_SRCH;
            end
            default:
            begin
                op.kind = OP_NONE;
            end
        endcase
    end

    assign in_ready   = enable && (count_reg < QCNT_W'(Q_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= op;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(Q_DEPTH))
        else $error("queue count past depth");

endmodule

>>> rtl/core/fpst_back.sv
module fpst_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  fpst_pkg::fpst_op_t            head,
    output logic                          pop,
    output logic                          clear_done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fpst_pkg::VAL_W-1:0]    prefix_total,
    output logic [fpst_pkg::FOUND_W-1:0]  found_position,
    output logic                          index_error
);
    import fpst_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_SRCH  = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    logic [SUM_BITS-1:0]  mem [NUM_POS];
    logic [SUM_BITS-1:0]  rdata_reg;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [SUM_BITS-1:0]  wr_data;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic [ADDR_BITS-1:0] clr_cnt_next;
    logic [NXT_BITS-1:0]  cur_reg;
    logic [NXT_BITS-1:0]  cur_next;
    logic [POS_BITS-1:0]  pos_reg;
    logic [POS_BITS-1:0]  pos_next;
    logic [POS_BITS-1:0]  step_reg;
    logic [POS_BITS-1:0]  step_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [SUM_BITS-1:0]  acc_reg;
    logic [SUM_BITS-1:0]  acc_next;
    logic [SUM_BITS-1:0]  operand_reg;
    logic [SUM_BITS-1:0]  operand_next;
    logic [SUM_BITS-1:0]  res_total_reg;
    logic [SUM_BITS-1:0]  res_total_next;
    logic [POS_BITS-1:0]  res_found_reg;
    logic [POS_BITS-1:0]  res_found_next;
    logic                 res_err_reg;
    logic                 res_err_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [VAL_W-1:0]     out_total_reg;
    logic [FOUND_W-1:0]   out_found_reg;
    logic                 out_err_reg;
    logic                 out_load;

    logic [NXT_BITS-1:0]  low_bit;
    logic [NXT_BITS-1:0]  up_nxt;
    logic [NXT_BITS-1:0]  down_nxt;
    logic [SUM_BITS-1:0]  node_sum;
    logic                 take;
    logic [POS_BITS-1:0]  srch_pos;
    logic [SUM_BITS-1:0]  srch_acc;
    logic [POS_BITS-1:0]  srch_step;
    logic [NXT_BITS-1:0]  srch_nxt;

    assign low_bit   = cur_reg & (~cur_reg + NXT_BITS'(1));
    assign up_nxt    = cur_reg + low_bit;
    assign down_nxt  = cur_reg - low_bit;
    assign node_sum  = acc_reg + rdata_reg;
    assign take      = pend_reg && ($signed(node_sum) < $signed(operand_reg));
    assign srch_pos  = take ? POS_BITS'(cur_reg) : pos_reg;
    assign srch_acc  = take ? node_sum : acc_reg;
    assign srch_step = step_reg >> 1;
    assign srch_nxt  = NXT_BITS'(srch_pos) + NXT_BITS'(srch_step);

    assign clear_done = (state_reg != ST_CLEAR);
    assign out_load   = (state_reg == ST_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        operand_next   = operand_reg;
        res_total_next = res_total_reg;
        res_found_next = res_found_reg;
        res_err_next   = res_err_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_BITS'(1);
                if (clr_cnt_reg == ADDR_BITS'(NUM_POS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop            = 1'b1;
                    operand_next   = head.operand;
                    acc_next       = '0;
                    cur_next       = NXT_BITS'(head.start);
                    res_total_next = '0;
                    res_found_next = '0;
                    res_err_next   = head.err;
                    case (head.kind)
                        OP_ADD:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_BITS'(head.start - POS_BITS'(1));
                            state_next = ST_ADD;
                        end
                        OP_SUM:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_BITS'(head.start - POS_BITS'(1));
                            state_next = ST_SUM;
                        end
                        OP_SRCH:
                        begin
                            pos_next   = '0;
                            step_next  = POS_BITS'(SEARCH_TOP);
                            cur_next   = NXT_BITS'(SEARCH_TOP);
                            pend_next  = 1'b1;
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_BITS'(SEARCH_TOP - 1);
                            state_next = ST_SRCH;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                wr_en   = 1'b1;
                wr_addr = ADDR_BITS'(cur_reg - NXT_BITS'(1));
                wr_data = rdata_reg + operand_reg;
                if (up_nxt <= NXT_BITS'(NUM_POS))
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ADDR_BITS'(up_nxt - NXT_BITS'(1));
                    cur_next = up_nxt;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SUM:
            begin
                acc_next = node_sum;
                if (down_nxt != '0)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ADDR_BITS'(down_nxt - NXT_BITS'(1));
                    cur_next = down_nxt;
                end
                else
                begin
                    res_total_next = node_sum;
                    state_next     = ST_RESP;
                end
            end
            ST_SRCH:
            begin
                pos_next  = srch_pos;
                acc_next  = srch_acc;
                step_next = srch_step;
                if (srch_step == '0)
                begin
                    res_found_next = srch_pos;
                    state_next     = ST_RESP;
                end
                else
                begin
                    cur_next  = srch_nxt;
                    pend_next = (srch_nxt <= NXT_BITS'(NUM_POS));
                    if (srch_nxt <= NXT_BITS'(NUM_POS))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_BITS'(srch_nxt - NXT_BITS'(1));
                    end
                end
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // tree store, one read and one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        pos_reg       <= pos_next;
        step_reg      <= step_next;
        pend_reg      <= pend_next;
        acc_reg       <= acc_next;
        operand_reg   <= operand_next;
        res_total_reg <= res_total_next;
        res_found_reg <= res_found_next;
        res_err_reg   <= res_err_next;
        if (out_load)
        begin
            out_total_reg <= VAL_W'($signed(res_total_reg));
            out_found_reg <= FOUND_W'(res_found_reg);
            out_err_reg   <= res_err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign prefix_total   = out_total_reg;
    assign found_position = out_found_reg;
    assign index_error    = out_err_reg;

    a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD || state_reg == ST_SUM)
        |-> (cur_reg != '0 && cur_reg <= NXT_BITS'(NUM_POS)))
        else $error("tree walk node out of range");

    a_srch_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) |-> (step_reg != '0 && pos_reg <= POS_BITS'(NUM_POS)))
        else $error("search walk lost its step");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != ST_IDLE && state_reg != ST_CLEAR))
        else $error("item taken but engine did not start");

    a_resp_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not presented");

endmodule
